// ===== design/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dcs_pkg: shared types and constants of the coincidence sorter
// Field widths, spectrum identifiers, register indexes, the configuration
// and job records, and the energy window test.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int CH_W         = 4;
    localparam int CH_FULL_W    = 16;
    localparam int WORD_W       = 32;
    localparam int ENERGY_W     = 14;
    localparam int DIFF_W       = 15;
    localparam int OFF_W        = 14;
    localparam int MAG_W        = 13;
    localparam int TS_W         = 5;
    localparam int GATE_BOUND_W = 13;
    localparam int GATES_W      = 52;
    localparam int SPEC_W       = 5;
    localparam int XBIN_W       = 14;
    localparam int YBIN_W       = 13;
    localparam int APB_AW       = 6;
    localparam int APB_DW       = 64;
    localparam int JOBQ_DEPTH   = 4;
    localparam int JOBQ_AW      = 2;

    localparam logic [ENERGY_W-1:0] E_MIN = 14'd20;

    // Spectrum identifiers.
    localparam logic [SPEC_W-1:0] SPEC_TIME      = 5'd16;
    localparam logic [SPEC_W-1:0] SPEC_EE        = 5'd17;
    localparam logic [SPEC_W-1:0] SPEC_E0T       = 5'd18;
    localparam logic [SPEC_W-1:0] SPEC_E1T       = 5'd19;
    localparam logic [SPEC_W-1:0] SPEC_GATE_BASE = 5'd20;
    localparam logic [SPEC_W-1:0] GATE_STRIDE    = 5'd3;

    // Register indexes; each register sits at byte address 8 * index.
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_COIN_ENABLE  = 3'd0;
    localparam t_reg_idx REG_CHANNEL_MASK = 3'd1;
    localparam t_reg_idx REG_COIN_A       = 3'd2;
    localparam t_reg_idx REG_COIN_B       = 3'd3;
    localparam t_reg_idx REG_TIME_SCALE   = 3'd4;
    localparam t_reg_idx REG_GATE_LOW     = 3'd5;
    localparam t_reg_idx REG_GATE_HIGH    = 3'd6;

    typedef struct packed {
        logic                 coin_enable;
        logic [15:0]          channel_mask;
        logic [CH_W-1:0]      coin_a;
        logic [CH_W-1:0]      coin_b;
        logic [TS_W-1:0]      time_scale;
        logic [GATES_W-1:0]   gate_low;
        logic [GATES_W-1:0]   gate_high;
    } t_cfg;

    // One unit of work for the back end: a singles increment or a pair.
    typedef struct packed {
        logic                       is_pair;
        logic [CH_W-1:0]            ch;
        logic [ENERGY_W-1:0]        e0;
        logic [ENERGY_W-1:0]        e1;
        logic signed [DIFF_W-1:0]   diff;
        logic [OFF_W-1:0]           off;
        logic                       eok;
    } t_job;

    function automatic logic f_energy_ok(input logic [ENERGY_W-1:0] e,
                                         input logic [ENERGY_W:0]   lim);
        return (e > E_MIN) && ({1'b0, e} < lim);
    endfunction

endpackage

// ===== design/dcs_front.sv =====
// ----------------------------------------------------------------------------
// dcs_front: word classifier
// Tracks the energy/timetag alternation and the previous pair, and turns
// each accepted word into at most one job for the back end.
// ----------------------------------------------------------------------------
module dcs_front #(
    parameter int BINS_1D = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcs_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    input  logic [dcs_pkg::WORD_W-1:0]    i_data_word,
    input  logic                          i_first_of_event,
    output logic                          o_job_valid,
    output dcs_pkg::t_job                 o_job
);
    import dcs_pkg::*;

    localparam int ELIM_W = ENERGY_W + 1;
    localparam int HALF   = BINS_1D / 2;
    localparam logic [ELIM_W-1:0] E_LIMIT  = ELIM_W'(BINS_1D);
    localparam logic [DIFF_W-1:0] HALF_OFF = DIFF_W'(HALF);

    logic                 r_odd;
    logic [CH_FULL_W-1:0] r_cur_channel;
    logic [ENERGY_W-1:0]  r_cur_energy;
    logic [CH_FULL_W-1:0] r_last_channel;
    logic [WORD_W-1:0]    r_last_timetag;
    logic [ENERGY_W-1:0]  r_last_energy;

    logic [CH_FULL_W-1:0] w_ch;
    logic [ENERGY_W-1:0]  w_e;
    logic                 w_odd;
    logic                 singles_ok;
    logic                 side_a;
    logic                 side_b;
    logic [WORD_W-1:0]    t0;
    logic [WORD_W-1:0]    t1;
    logic [WORD_W-1:0]    d;
    logic                 in_range;
    logic                 pair_ok;
    logic                 is_pair_word;
    logic [DIFF_W-1:0]    off_sum;

    always_comb begin
        w_ch       = i_data_word[WORD_W-1:CH_FULL_W];
        w_e        = i_data_word[CH_FULL_W-1:2];
        w_odd      = r_odd && !i_first_of_event;
        singles_ok = f_energy_ok(w_e, E_LIMIT) && (w_ch[CH_FULL_W-1:CH_W] == '0)
                     && i_cfg.channel_mask[w_ch[CH_W-1:0]];

        // Side a wins when both coincidence channels are the same.
        side_a = (r_cur_channel == CH_FULL_W'(i_cfg.coin_a));
        side_b = (r_cur_channel == CH_FULL_W'(i_cfg.coin_b));
        t0     = side_a ? i_data_word : r_last_timetag;
        t1     = side_a ? r_last_timetag : i_data_word;
        d      = t0 - t1;
        in_range = ($signed(d) > -HALF) && ($signed(d) < HALF);
        pair_ok  = (r_last_channel != r_cur_channel) && (side_a || side_b) && in_range;
        off_sum  = d[DIFF_W-1:0] + HALF_OFF;

        is_pair_word = i_cfg.coin_enable && w_odd;
        o_job_valid  = i_valid && (is_pair_word ? pair_ok : singles_ok);

        o_job.is_pair = is_pair_word;
        o_job.ch      = w_ch[CH_W-1:0];
        o_job.e0      = is_pair_word ? (side_a ? r_cur_energy : r_last_energy) : w_e;
        o_job.e1      = side_a ? r_last_energy : r_cur_energy;
        o_job.diff    = $signed(d[DIFF_W-1:0]);
        o_job.off     = off_sum[OFF_W-1:0];
        o_job.eok     = f_energy_ok(r_cur_energy, E_LIMIT)
                        && f_energy_ok(r_last_energy, E_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd          <= 1'b0;
            r_cur_channel  <= '0;
            r_cur_energy   <= '0;
            r_last_channel <= '0;
            r_last_timetag <= '0;
            r_last_energy  <= '0;
        end else if (i_valid) begin
            if (i_first_of_event) begin
                r_odd          <= 1'b0;
                r_last_channel <= w_ch;
            end
            if (i_cfg.coin_enable) begin
                if (!w_odd) begin
                    r_cur_channel <= w_ch;
                    r_cur_energy  <= w_e;
                    r_odd         <= 1'b1;
                end else begin
                    r_last_channel <= r_cur_channel;
                    r_last_timetag <= i_data_word;
                    r_last_energy  <= r_cur_energy;
                    r_odd          <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== design/dcs_job_fifo.sv =====
// ----------------------------------------------------------------------------
// dcs_job_fifo: job queue between classifier and emitter
// A small first-in first-out queue of job records.
// ----------------------------------------------------------------------------
module dcs_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dcs_pkg::t_job  i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output dcs_pkg::t_job  o_rdata,
    output logic           o_empty
);
    import dcs_pkg::*;

    t_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] r_wptr;
    logic [JOBQ_AW-1:0] r_rptr;
    logic [JOBQ_AW:0]   r_count;

    assign o_full  = (r_count == (JOBQ_AW + 1)'(JOBQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/dcs_back.sv =====
// ----------------------------------------------------------------------------
// dcs_back: increment emitter
// Expands a job into bin increments through an output register, one per cycle
// unless the output stalls; a bit-serial divider scales the time difference.
// ----------------------------------------------------------------------------
module dcs_back #(
    parameter int BINS_2D   = 512,
    parameter int NUM_GATES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dcs_pkg::t_cfg                        i_cfg,
    input  logic                                 i_job_valid,
    input  dcs_pkg::t_job                        i_job,
    output logic                                 o_job_take,
    output logic                                 o_out_valid,
    input  logic                                 i_out_take,
    output logic [dcs_pkg::SPEC_W-1:0]           o_spectrum_id,
    output logic signed [dcs_pkg::XBIN_W-1:0]    o_x_bin,
    output logic [dcs_pkg::YBIN_W-1:0]           o_y_bin,
    output logic                                 o_last_of_run
);
    import dcs_pkg::*;

    localparam int GI_W = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
    localparam logic [DIFF_W-1:0] BIN2D_HALF = DIFF_W'(BINS_2D / 2);
    localparam logic [3:0] DIV_LAST = 4'(MAG_W - 1);
    localparam logic [1:0] GSUB_EE  = 2'd0;
    localparam logic [1:0] GSUB_E0  = 2'd1;
    localparam logic [1:0] GSUB_E1  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SINGLE, ST_TIME, ST_DIV, ST_EE, ST_E0T, ST_E1T, ST_GATE
    } t_state;

    t_state                  r_state;
    t_job                    r_job;
    logic [NUM_GATES-1:0]    r_hits;
    logic [1:0]              r_gsub;
    logic [TS_W-1:0]         r_rem;
    logic [MAG_W-1:0]        r_num;
    logic [3:0]              r_cnt;
    logic                    r_neg;
    logic                    r_out_valid;
    logic [SPEC_W-1:0]       r_out_id;
    logic [XBIN_W-1:0]       r_out_x;
    logic [YBIN_W-1:0]       r_out_y;
    logic                    r_out_last;

    logic [TS_W-1:0]         ts;
    logic [TS_W:0]           trial;
    logic                    trial_ge;
    logic [TS_W-1:0]         n_rem;
    logic [NUM_GATES-1:0]    load_hits;
    logic [DIFF_W-1:0]       neg_diff;
    logic [MAG_W-1:0]        load_mag;
    logic [GI_W-1:0]         gate_idx;
    logic [NUM_GATES-1:0]    hits_rest;
    logic [DIFF_W-1:0]       quo_signed;
    logic [DIFF_W-1:0]       dsc;
    logic [YBIN_W-1:0]       y_e0;
    logic [YBIN_W-1:0]       y_e1;
    logic                    out_free;
    logic                    do_emit;
    logic [SPEC_W-1:0]       n_id;
    logic [XBIN_W-1:0]       n_x;
    logic [YBIN_W-1:0]       n_y;
    logic                    n_last;

    assign o_out_valid   = r_out_valid;
    assign o_spectrum_id = r_out_id;
    assign o_x_bin       = $signed(r_out_x);
    assign o_y_bin       = r_out_y;
    assign o_last_of_run = r_out_last;
    assign o_job_take    = (r_state == ST_IDLE) && i_job_valid;

    always_comb begin
        // A zero time scale acts as one.
        ts       = (i_cfg.time_scale == '0) ? TS_W'(1) : i_cfg.time_scale;
        trial    = {r_rem, r_num[MAG_W-1]};
        trial_ge = (trial >= {1'b0, ts});
        n_rem    = trial_ge ? TS_W'(trial - {1'b0, ts}) : trial[TS_W-1:0];

        for (int g = 0; g < NUM_GATES; g++) begin
            load_hits[g] =
                (i_job.off >= {1'b0, i_cfg.gate_low[g*GATE_BOUND_W +: GATE_BOUND_W]}) &&
                (i_job.off <= {1'b0, i_cfg.gate_high[g*GATE_BOUND_W +: GATE_BOUND_W]});
        end
        neg_diff = -i_job.diff;
        load_mag = i_job.diff[DIFF_W-1] ? neg_diff[MAG_W-1:0] : i_job.diff[MAG_W-1:0];

        gate_idx = '0;
        for (int g = NUM_GATES - 1; g >= 0; g--) begin
            if (r_hits[g]) begin
                gate_idx = GI_W'(g);
            end
        end
        hits_rest = r_hits & (r_hits - NUM_GATES'(1));

        quo_signed = r_neg ? -DIFF_W'(r_num) : DIFF_W'(r_num);
        dsc        = quo_signed + BIN2D_HALF;
        y_e0       = YBIN_W'(r_job.e0 >> 2);
        y_e1       = YBIN_W'(r_job.e1 >> 2);

        out_free = !r_out_valid || i_out_take;
        do_emit  = 1'b0;
        n_id     = r_job.ch;
        n_x      = r_job.e0;
        n_y      = '0;
        n_last   = 1'b0;
        case (r_state)
            ST_SINGLE: begin
                do_emit = out_free;
                n_last  = 1'b1;
            end
            ST_TIME: begin
                do_emit = out_free;
                n_id    = SPEC_TIME;
                n_x     = r_job.off;
                n_last  = !r_job.eok;
            end
            ST_EE: begin
                do_emit = out_free;
                n_id    = SPEC_EE;
                n_x     = XBIN_W'(y_e1);
                n_y     = y_e0;
            end
            ST_E0T: begin
                do_emit = out_free;
                n_id    = SPEC_E0T;
                n_x     = dsc[XBIN_W-1:0];
                n_y     = y_e0;
            end
            ST_E1T: begin
                do_emit = out_free;
                n_id    = SPEC_E1T;
                n_x     = dsc[XBIN_W-1:0];
                n_y     = y_e1;
                n_last  = (r_hits == '0);
            end
            ST_GATE: begin
                do_emit = out_free;
                n_id    = SPEC_GATE_BASE + SPEC_W'(gate_idx) * GATE_STRIDE
                          + SPEC_W'(r_gsub);
                case (r_gsub)
                    GSUB_EE: begin
                        n_x = XBIN_W'(y_e1);
                        n_y = y_e0;
                    end
                    GSUB_E0: n_x = r_job.e0;
                    default: begin
                        n_x    = r_job.e1;
                        n_last = (hits_rest == '0);
                    end
                endcase
            end
            default: do_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_gsub      <= '0;
            r_cnt       <= '0;
        end else begin
            if (do_emit) begin
                r_out_valid <= 1'b1;
                r_out_id    <= n_id;
                r_out_x     <= n_x;
                r_out_y     <= n_y;
                r_out_last  <= n_last;
            end else if (i_out_take) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_hits  <= load_hits;
                        r_neg   <= i_job.diff[DIFF_W-1];
                        r_num   <= load_mag;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_gsub  <= GSUB_EE;
                        r_state <= i_job.is_pair ? ST_TIME : ST_SINGLE;
                    end
                end
                ST_SINGLE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_TIME: begin
                    if (out_free) begin
                        r_state <= r_job.eok ? ST_DIV : ST_IDLE;
                    end
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_num <= {r_num[MAG_W-2:0], trial_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_EE;
                    end
                end
                ST_EE: begin
                    if (out_free) begin
                        r_state <= ST_E0T;
                    end
                end
                ST_E0T: begin
                    if (out_free) begin
                        r_state <= ST_E1T;
                    end
                end
                ST_E1T: begin
                    if (out_free) begin
                        r_state <= (r_hits != '0) ? ST_GATE : ST_IDLE;
                    end
                end
                ST_GATE: begin
                    if (out_free) begin
                        if (r_gsub == GSUB_E1) begin
                            r_gsub <= GSUB_EE;
                            r_hits <= hits_rest;
                            if (hits_rest == '0) begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_gsub <= r_gsub + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== design/digitizer_coincidence_sorter_core.sv =====
// ----------------------------------------------------------------------------
// digitizer_coincidence_sorter_core: histogram increment sorter
// Sorts digitizer energy and timetag words into singles, time-difference,
// energy-versus-energy, energy-versus-time and gated bin increments.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake               | Carries
//  ----------+-------------------------+----------------------------------------
//  input     | push / full             | data_word, first_of_event
//  result    | empty / pop             | spectrum_id, x_bin, y_bin, last_of_run
//  register  | psel/penable/pwrite     | paddr, pwdata, prdata (8-byte stride)
//
// An accepted word is classified in the cycle of its transfer and leaves at
// most one job in a four-entry queue. The emitter takes one job per visit to
// idle and puts out one increment per cycle, unless the result side stalls,
// through its output register. A singles job gives one increment; a pair
// job gives a time-difference increment and, when both energies are valid,
// runs the bit-serial division by time_scale before its three energy
// increments and three more for each gate that is hit.
// Reset is synchronous and active low; it restores the register defaults,
// clears the pairing state and empties both queues. A stalled result side
// fills the job queue, after which full holds input transfers back.
//
module digitizer_coincidence_sorter_core #(
    parameter int BINS_1D   = 8192,
    parameter int BINS_2D   = 512,
    parameter int NUM_GATES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input queue side.
    input  logic                                push,
    output logic                                full,
    input  logic [dcs_pkg::WORD_W-1:0]          i_data_word,
    input  logic                                i_first_of_event,
    // Result queue side.
    output logic                                empty,
    input  logic                                pop,
    output logic [dcs_pkg::SPEC_W-1:0]          o_spectrum_id,
    output logic signed [dcs_pkg::XBIN_W-1:0]   o_x_bin,
    output logic [dcs_pkg::YBIN_W-1:0]          o_y_bin,
    output logic                                o_last_of_run,
    // Register port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcs_pkg::APB_AW-1:0]          paddr,
    input  logic [dcs_pkg::APB_DW-1:0]          pwdata,
    output logic [dcs_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import dcs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     in_transfer;
    logic     job_wr;
    t_job     job_in;
    logic     job_full;
    logic     job_empty;
    t_job     job_out;
    logic     job_take;
    logic     out_valid;

    // Registers sit on an eight-byte stride since the gate bounds need 52 bits.
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coin_enable  <= 1'b1;
            r_cfg.channel_mask <= 16'd3;
            r_cfg.coin_a       <= 4'd0;
            r_cfg.coin_b       <= 4'd1;
            r_cfg.time_scale   <= 5'd1;
            r_cfg.gate_low     <= '0;
            r_cfg.gate_high    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COIN_ENABLE:  r_cfg.coin_enable  <= pwdata[0];
                REG_CHANNEL_MASK: r_cfg.channel_mask <= pwdata[15:0];
                REG_COIN_A:       r_cfg.coin_a       <= pwdata[CH_W-1:0];
                REG_COIN_B:       r_cfg.coin_b       <= pwdata[CH_W-1:0];
                REG_TIME_SCALE:   r_cfg.time_scale   <= pwdata[TS_W-1:0];
                REG_GATE_LOW:     r_cfg.gate_low     <= pwdata[GATES_W-1:0];
                REG_GATE_HIGH:    r_cfg.gate_high    <= pwdata[GATES_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COIN_ENABLE:  prdata = APB_DW'(r_cfg.coin_enable);
            REG_CHANNEL_MASK: prdata = APB_DW'(r_cfg.channel_mask);
            REG_COIN_A:       prdata = APB_DW'(r_cfg.coin_a);
            REG_COIN_B:       prdata = APB_DW'(r_cfg.coin_b);
            REG_TIME_SCALE:   prdata = APB_DW'(r_cfg.time_scale);
            REG_GATE_LOW:     prdata = APB_DW'(r_cfg.gate_low);
            REG_GATE_HIGH:    prdata = APB_DW'(r_cfg.gate_high);
            default:          prdata = '0;
        endcase
    end

    // The input side only waits when the job queue is full.
    assign full        = job_full;
    assign in_transfer = push && !job_full;
    assign empty       = !out_valid;

    dcs_front #(
        .BINS_1D (BINS_1D)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (in_transfer),
        .i_data_word      (i_data_word),
        .i_first_of_event (i_first_of_event),
        .o_job_valid      (job_wr),
        .o_job            (job_in)
    );

    dcs_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_wdata (job_in),
        .o_full  (job_full),
        .i_rd    (job_take),
        .o_rdata (job_out),
        .o_empty (job_empty)
    );

    dcs_back #(
        .BINS_2D   (BINS_2D),
        .NUM_GATES (NUM_GATES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_job_valid   (!job_empty),
        .i_job         (job_out),
        .o_job_take    (job_take),
        .o_out_valid   (out_valid),
        .i_out_take    (pop),
        .o_spectrum_id (o_spectrum_id),
        .o_x_bin       (o_x_bin),
        .o_y_bin       (o_y_bin),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== design/dcs_checker.sv =====
// ----------------------------------------------------------------------------
// dcs_checker: port-level checks of the sorter
// Watches the top level's ports and flags reset, hold and framing slips.
// ----------------------------------------------------------------------------
module dcs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                push,
    input logic                                full,
    input logic [dcs_pkg::WORD_W-1:0]          i_data_word,
    input logic                                i_first_of_event,
    input logic                                empty,
    input logic                                pop,
    input logic [dcs_pkg::SPEC_W-1:0]          o_spectrum_id,
    input logic signed [dcs_pkg::XBIN_W-1:0]   o_x_bin,
    input logic [dcs_pkg::YBIN_W-1:0]          o_y_bin,
    input logic                                o_last_of_run,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [dcs_pkg::APB_AW-1:0]          paddr,
    input logic [dcs_pkg::APB_DW-1:0]          pwdata,
    input logic [dcs_pkg::APB_DW-1:0]          prdata,
    input logic                                pready
);
    import dcs_pkg::*;

    // Reset leaves both queues empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A waiting result holds until its transfer.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_spectrum_id) && $stable(o_x_bin)
                           && $stable(o_y_bin) && $stable(o_last_of_run))
        else $error("waiting result changed");

    // A singles increment is the only result of its word and is 1D.
    a_singles_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_spectrum_id < SPEC_TIME) |-> o_last_of_run && (o_y_bin == '0))
        else $error("singles increment framed wrongly");

    // Increments that are always followed by others never close a word.
    a_head_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_spectrum_id == SPEC_EE || o_spectrum_id == SPEC_E0T
                   || o_spectrum_id == SPEC_GATE_BASE
                   || o_spectrum_id == SPEC_GATE_BASE + GATE_STRIDE
                   || o_spectrum_id == SPEC_GATE_BASE + 5'd2 * GATE_STRIDE
                   || o_spectrum_id == SPEC_GATE_BASE + 5'd3 * GATE_STRIDE)
        |-> !o_last_of_run)
        else $error("word closed early");

endmodule

bind digitizer_coincidence_sorter_core dcs_checker u_dcs_checker (.*);

// ===== test/digitizer_coincidence_sorter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// digitizer_coincidence_sorter_core_tb: self-checking bench of the sorter
// Feeds energy and timetag words through the push/full side, pops bin
// increments with random stalls, predicts every increment in step with the
// accepted words and compares them field by field in arrival order.
// ----------------------------------------------------------------------------
module digitizer_coincidence_sorter_core_tb;

    import dcs_pkg::*;

    // Histogram geometry; these match the default parameters of the block.
    localparam int HIST_BINS_1D = 8192;
    localparam int HIST_BINS_2D = 512;
    localparam int E_FLOOR      = 20;
    localparam int NUM_WINDOWS  = 4;

    // The slowest job is a pair with all four gates hit and the job queue
    // holds four, so this many quiet cycles cover any word that is still being
    // sorted without causing an increment.
    localparam int QUIET_CYCLES = 160;
    localparam int CYCLE_LIMIT  = 200000;

    // One bin increment as it appears on the result side.
    typedef struct packed {
        logic [SPEC_W-1:0] spectrum_id;
        logic [XBIN_W-1:0] x_bin;
        logic [YBIN_W-1:0] y_bin;
        logic              last_of_run;
    } incr_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       push;
    logic                       full;
    logic [WORD_W-1:0]          i_data_word;
    logic                       i_first_of_event;
    logic                       empty;
    logic                       pop;
    logic [SPEC_W-1:0]          o_spectrum_id;
    logic signed [XBIN_W-1:0]   o_x_bin;
    logic [YBIN_W-1:0]          o_y_bin;
    logic                       o_last_of_run;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    // Increments predicted from accepted words and not yet popped.
    incr_t pending_incr_q[$];

    // Register settings as the block should hold them, starting at reset.
    t_cfg cfg = '{coin_enable: 1'b1, channel_mask: 16'h0003, coin_a: 4'd0,
                  coin_b: 4'd1, time_scale: 5'd1, gate_low: '0, gate_high: '0};

    // Pairing state of the sorter: whether the next word is a timetag, the
    // energy word of the open pair, and the channel, timetag and energy of
    // the previous completed pair.
    logic                  at_timetag = 1'b0;
    logic [CH_FULL_W-1:0]  cur_ch     = '0;
    logic [ENERGY_W-1:0]   cur_e      = '0;
    logic [CH_FULL_W-1:0]  prev_ch    = '0;
    logic [WORD_W-1:0]     prev_tt    = '0;
    logic [ENERGY_W-1:0]   prev_e     = '0;

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  idle_on     = 1'b1;   // random gaps on both sides when set
    int  rx_hold     = 0;      // long receiver stall, counted down in cycles
    int  rx_gap      = 0;

    digitizer_coincidence_sorter_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_word      (i_data_word),
        .i_first_of_event (i_first_of_event),
        .empty            (empty),
        .pop              (pop),
        .o_spectrum_id    (o_spectrum_id),
        .o_x_bin          (o_x_bin),
        .o_y_bin          (o_y_bin),
        .o_last_of_run    (o_last_of_run),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void add_increment(input logic [SPEC_W-1:0] id, input int x,
                                          input logic [YBIN_W-1:0] y);
        incr_t inc;
        inc.spectrum_id = id;
        inc.x_bin       = XBIN_W'(x);
        inc.y_bin       = y;
        inc.last_of_run = 1'b0;
        pending_incr_q.push_back(inc);
    endfunction

    function automatic bit energy_in_window(input logic [ENERGY_W-1:0] e);
        return (int'(e) > E_FLOOR) && (int'(e) < HIST_BINS_1D);
    endfunction

    // A singles increment exists only for channels 0-15 whose mask bit is set.
    function automatic void add_singles(input logic [CH_FULL_W-1:0] ch,
                                        input logic [ENERGY_W-1:0] e);
        if (energy_in_window(e) && ch < 16 && cfg.channel_mask[ch[3:0]])
            add_increment(SPEC_W'(ch[3:0]), int'(e), '0);
    endfunction

    // Coincidence of the open pair with the previous pair. Side a wins when
    // both coincidence channels are equal; any other channel is dropped.
    function automatic void add_coincidence(input logic [WORD_W-1:0] tt);
        logic [WORD_W-1:0]   t0, t1;
        logic [ENERGY_W-1:0] e0, e1;
        int                  diff, off, dsc, ts, lo, hi, g;
        if (cur_ch == CH_FULL_W'(cfg.coin_a)) begin
            t0 = tt;
            t1 = prev_tt;
            e0 = cur_e;
            e1 = prev_e;
        end else if (cur_ch == CH_FULL_W'(cfg.coin_b)) begin
            t0 = prev_tt;
            t1 = tt;
            e0 = prev_e;
            e1 = cur_e;
        end else begin
            return;
        end
        // The timetag difference wraps around 2^32 and is read as signed.
        diff = int'(t0 - t1);
        if (!(diff > -(HIST_BINS_1D / 2) && diff < HIST_BINS_1D / 2))
            return;
        off = diff + HIST_BINS_1D / 2;
        add_increment(SPEC_TIME, off, '0);
        if (!(energy_in_window(e0) && energy_in_window(e1)))
            return;
        // A zero time scale divides by one; the division truncates toward zero.
        ts  = (cfg.time_scale == '0) ? 1 : int'(cfg.time_scale);
        dsc = diff / ts + HIST_BINS_2D / 2;
        add_increment(SPEC_EE, int'(e1 >> 2), YBIN_W'(e0 >> 2));
        add_increment(SPEC_E0T, dsc, YBIN_W'(e0 >> 2));
        add_increment(SPEC_E1T, dsc, YBIN_W'(e1 >> 2));
        for (g = 0; g < NUM_WINDOWS; g++) begin
            lo = int'(cfg.gate_low[GATE_BOUND_W*g +: GATE_BOUND_W]);
            hi = int'(cfg.gate_high[GATE_BOUND_W*g +: GATE_BOUND_W]);
            if (off >= lo && off <= hi) begin
                add_increment(SPEC_GATE_BASE + GATE_STRIDE * SPEC_W'(g),
                              int'(e1 >> 2), YBIN_W'(e0 >> 2));
                add_increment(SPEC_GATE_BASE + GATE_STRIDE * SPEC_W'(g) + 5'd1,
                              int'(e0), '0);
                add_increment(SPEC_GATE_BASE + GATE_STRIDE * SPEC_W'(g) + 5'd2,
                              int'(e1), '0);
            end
        end
    endfunction

    // Works out every increment caused by one accepted word and queues them.
    function automatic void sort_word(input logic [WORD_W-1:0] word, input logic first);
        logic [CH_FULL_W-1:0] ch;
        logic [ENERGY_W-1:0]  e;
        int                   n_before;
        incr_t                tail;
        ch       = word[31:16];
        e        = word[15:2];
        n_before = pending_incr_q.size();
        // The first word of an event restarts pairing, and its channel stands
        // in as the previous one so that the first timetag cannot pair.
        if (first) begin
            at_timetag = 1'b0;
            prev_ch    = ch;
        end
        if (!cfg.coin_enable) begin
            add_singles(ch, e);
        end else if (!at_timetag) begin
            add_singles(ch, e);
            cur_ch     = ch;
            cur_e      = e;
            at_timetag = 1'b1;
        end else begin
            if (prev_ch != cur_ch)
                add_coincidence(word);
            prev_ch    = cur_ch;
            prev_tt    = word;
            prev_e     = cur_e;
            at_timetag = 1'b0;
        end
        if (pending_incr_q.size() > n_before) begin
            tail = pending_incr_q.pop_back();
            tail.last_of_run = 1'b1;
            pending_incr_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_increment();
        incr_t want;
        if (pending_incr_q.size() == 0) begin
            $error("increment with none expected: spectrum_id %0d x_bin %0d y_bin %0d",
                   o_spectrum_id, o_x_bin, o_y_bin);
            fail_count++;
        end else begin
            want = pending_incr_q.pop_front();
            check_field("spectrum_id", want.spectrum_id, o_spectrum_id);
            check_field("x_bin", $signed(want.x_bin), $signed(o_x_bin));
            check_field("y_bin", want.y_bin, o_y_bin);
            check_field("last_of_run", want.last_of_run, o_last_of_run);
        end
    endfunction

    // Both transfers are observed at the rising edge. Results are checked
    // before the word of the same edge is sorted; that word cannot have an
    // increment out yet anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                check_increment();
            if (push && !full)
                sort_word(i_data_word, i_first_of_event);
        end
    end

    // Result side: after each transfer the receiver may pause for a few
    // cycles, and a long hold requested by a test keeps pop low throughout.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                pop <= 1'b0;
                rx_hold--;
            end else if (rx_gap > 0) begin
                pop <= 1'b0;
                rx_gap--;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty)
                rx_gap = idle_on ? $urandom_range(0, 5) : 0;
        end
    end

    // ------------------------------------------------------------------------
    // Input side and register port
    // ------------------------------------------------------------------------

    // Offers one word and returns at the edge of its transfer. push stays
    // high when no gap is drawn, so back-to-back words need no dead cycle.
    task automatic send_word(input logic [WORD_W-1:0] word, input logic first);
        int gap;
        @(negedge i_clk);
        push             <= 1'b1;
        i_data_word      <= word;
        i_first_of_event <= first;
        do @(posedge i_clk); while (full);
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Lets the block run dry: every expected increment popped, then enough
    // quiet cycles for a word that leaves no increment.
    task automatic settle_block();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_incr_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [APB_DW-1:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_COIN_ENABLE:  return APB_DW'(cfg.coin_enable);
            REG_CHANNEL_MASK: return APB_DW'(cfg.channel_mask);
            REG_COIN_A:       return APB_DW'(cfg.coin_a);
            REG_COIN_B:       return APB_DW'(cfg.coin_b);
            REG_TIME_SCALE:   return APB_DW'(cfg.time_scale);
            REG_GATE_LOW:     return APB_DW'(cfg.gate_low);
            REG_GATE_HIGH:    return APB_DW'(cfg.gate_high);
            default:          return '0;
        endcase
    endfunction

    // Setup and access cycle of a write, then a read of the same register
    // whose data must match what was just written.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_COIN_ENABLE:  cfg.coin_enable  = value[0];
            REG_CHANNEL_MASK: cfg.channel_mask = value[15:0];
            REG_COIN_A:       cfg.coin_a       = value[CH_W-1:0];
            REG_COIN_B:       cfg.coin_b       = value[CH_W-1:0];
            REG_TIME_SCALE:   cfg.time_scale   = value[TS_W-1:0];
            REG_GATE_LOW:     cfg.gate_low     = value[GATES_W-1:0];
            REG_GATE_HIGH:    cfg.gate_high    = value[GATES_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field($sformatf("register %0d readback", idx), reg_value(idx), prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Rewrites every register; the block is drained first.
    task automatic write_config(input bit en, input logic [15:0] mask,
                                input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                input logic [TS_W-1:0] ts,
                                input logic [GATES_W-1:0] lo_bounds,
                                input logic [GATES_W-1:0] hi_bounds);
        settle_block();
        write_reg(REG_COIN_ENABLE, APB_DW'(en));
        write_reg(REG_CHANNEL_MASK, APB_DW'(mask));
        write_reg(REG_COIN_A, APB_DW'(a));
        write_reg(REG_COIN_B, APB_DW'(b));
        write_reg(REG_TIME_SCALE, APB_DW'(ts));
        write_reg(REG_GATE_LOW, APB_DW'(lo_bounds));
        write_reg(REG_GATE_HIGH, APB_DW'(hi_bounds));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [GATES_W-1:0] pack_gates(input int g0, input int g1,
                                                      input int g2, input int g3);
        return {13'(g3), 13'(g2), 13'(g1), 13'(g0)};
    endfunction

    // Energy word with random charge bits below the energy.
    function automatic logic [WORD_W-1:0] energy_word(input logic [CH_FULL_W-1:0] ch,
                                                      input logic [ENERGY_W-1:0] e);
        return {ch, e, 2'($urandom)};
    endfunction

    // Mostly the two coincidence channels, sometimes any low channel or a
    // channel number beyond the singles range.
    function automatic logic [CH_FULL_W-1:0] pick_channel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CH_FULL_W'(cfg.coin_a);
        else if (r < 8)
            return CH_FULL_W'(cfg.coin_b);
        else if (r == 8)
            return CH_FULL_W'($urandom_range(0, 15));
        return CH_FULL_W'($urandom);
    endfunction

    // Mostly inside the energy window, with its edges and wild values mixed in.
    function automatic logic [ENERGY_W-1:0] pick_energy();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 5))
                0: return 14'd0;
                1: return 14'd20;
                2: return 14'd21;
                3: return 14'd8191;
                4: return 14'd8192;
                default: return 14'd16383;
            endcase
        end else if (r == 1) begin
            return ENERGY_W'($urandom);
        end
        return ENERGY_W'($urandom_range(E_FLOOR + 1, HIST_BINS_1D - 1));
    endfunction

    // A well-formed event: energy and timetag words alternating, timetags
    // spread around a common base so that most pairs fall inside the time
    // window. Now and then a stray word or a restart breaks the sequence.
    task automatic send_event(input int n_pairs);
        logic [WORD_W-1:0] tt_base;
        int                k;
        tt_base = $urandom;
        for (k = 0; k < n_pairs; k++) begin
            if ($urandom_range(0, 14) == 0)
                send_word($urandom, 1'($urandom));
            send_word(energy_word(pick_channel(), pick_energy()),
                      (k == 0) || ($urandom_range(0, 19) == 0));
            send_word(tt_base + $urandom_range(0, 10000) - 5000, 1'b0);
        end
    endtask

    task automatic randomize_config();
        logic [CH_W-1:0]    a, b;
        logic [GATES_W-1:0] lo_bounds, hi_bounds;
        int                 g, lo;
        a = $urandom_range(0, 15);
        b = ($urandom_range(0, 3) == 0) ? a : CH_W'($urandom_range(0, 15));
        for (g = 0; g < NUM_WINDOWS; g++) begin
            lo = $urandom_range(1000, 7000);
            lo_bounds[GATE_BOUND_W*g +: GATE_BOUND_W] = 13'(lo);
            // Some windows come out inverted or wrapped; those never hit.
            hi_bounds[GATE_BOUND_W*g +: GATE_BOUND_W] = 13'(lo + $urandom_range(0, 3000) - 400);
        end
        write_config(1'b1, 16'($urandom_range(0, 65535)), a, b,
                     TS_W'($urandom_range(1, 16)), lo_bounds, hi_bounds);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked words that walk through the special cases of the sorter:
    // energy window edges, the first timetag of an event, equal channels,
    // channels outside both sides or beyond 15, the edges of the time window
    // across the 2^32 wrap, gate edges and an inverted gate, a zero time
    // scale, and both coincidence channels set alike.
    task automatic test_directed_cases();
        idle_on = 1'b1;
        write_config(1'b1, 16'hFFFF, 4'd2, 4'd5, 5'd0,
                     pack_gates(4090, 4000, 0, 8191), pack_gates(4090, 4100, 8191, 0));
        send_word(energy_word(16'd2, 14'd21), 1'b1);
        send_word(32'hFFFF_FFF0, 1'b0);                 // first timetag: no pair
        send_word(energy_word(16'd5, 14'd8191), 1'b0);
        send_word(32'h0000_0005, 1'b0);                 // pair across the wrap
        send_word(energy_word(16'd2, 14'd4000), 1'b0);
        send_word(32'h0000_1004, 1'b0);                 // difference of 4095 counts
        send_word(energy_word(16'd5, 14'd500), 1'b0);
        send_word(32'h0000_2004, 1'b0);                 // difference of 4096 does not
        send_word(energy_word(16'd7, 14'd300), 1'b0);
        send_word(32'h0000_2010, 1'b0);                 // channel on neither side
        send_word(energy_word(16'd5, 14'd300), 1'b1);   // restart within the stream
        send_word(32'h0000_3000, 1'b0);
        send_word(energy_word(16'd5, 14'd200), 1'b0);
        send_word(32'h0000_3001, 1'b0);                 // same channel: no pair
        send_word(energy_word(16'hFFFF, 14'd5000), 1'b0);
        send_word(32'h0000_3002, 1'b0);
        send_word(energy_word(16'd2, 14'd1000), 1'b0);
        send_word(32'h0000_3002, 1'b0);                 // zero difference
        // Both coincidence channels on 3: side a decides the order.
        write_config(1'b1, 16'hFFFF, 4'd3, 4'd3, 5'd16,
                     pack_gates(0, 0, 0, 0), pack_gates(8191, 0, 0, 0));
        send_word(energy_word(16'd3, 14'd700), 1'b1);
        send_word(32'h0000_0064, 1'b0);
        send_word(energy_word(16'd4, 14'd800), 1'b0);
        send_word(32'h0000_00C8, 1'b0);
        send_word(energy_word(16'd3, 14'd900), 1'b0);
        send_word(32'h0000_0032, 1'b0);
    endtask

    // With pairing off every word is an energy word; the pairing state is
    // kept, so the next phase starts from wherever this one left it.
    task automatic test_coincidence_off();
        int k;
        idle_on = 1'b1;
        write_config(1'b0, 16'hFFFF, cfg.coin_a, cfg.coin_b, cfg.time_scale,
                     cfg.gate_low, cfg.gate_high);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0053, 1'b0);                 // energy 20: below the window
        send_word(32'h0001_0057, 1'b0);                 // energy 21: inside
        send_word(32'h000F_7FFF, 1'b0);                 // energy 8191 on channel 15
        send_word(32'h000F_8000, 1'b0);                 // energy 8192: above
        send_word(32'hFFFF_FFFF, 1'b0);
        for (k = 0; k < 16; k++) begin
            if (k[0])
                send_word({16'($urandom_range(0, 17)), 16'($urandom)},
                          $urandom_range(0, 3) == 0);
            else
                send_word($urandom, $urandom_range(0, 3) == 0);
        end
    endtask

    // Register extremes: every gate wide open (the most increments per
    // pair), then every gate shut, with the mask and channels at both ends.
    task automatic test_config_extremes();
        idle_on = 1'b1;
        write_config(1'b1, 16'h0000, 4'd0, 4'd15, 5'd16, '0, {GATES_W{1'b1}});
        repeat (3) send_event(2);
        write_config(1'b1, 16'hFFFF, 4'd15, 4'd0, 5'd1, {GATES_W{1'b1}}, '0);
        repeat (3) send_event(2);
    endtask

    // Random settings per phase; one phase runs without any idling.
    task automatic test_random_events();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            randomize_config();
            idle_on = (phase != 1);
            repeat (4) send_event($urandom_range(1, 3));
        end
        idle_on = 1'b1;
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // job queue fills and full must hold the sender back without loss.
    task automatic test_result_backpressure();
        write_config(1'b1, 16'hFFFF, 4'd0, 4'd1, 5'd3, '0, {GATES_W{1'b1}});
        idle_on = 1'b0;
        rx_hold = 400;
        repeat (4) send_event(2);
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        push             = 1'b0;
        i_data_word      = '0;
        i_first_of_event = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_coincidence_off();
        test_config_extremes();
        test_random_events();
        test_result_backpressure();

        settle_block();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== digitizer_coincidence_sorter_core.f =====
design/dcs_pkg.sv
design/dcs_front.sv
design/dcs_job_fifo.sv
design/dcs_back.sv
design/digitizer_coincidence_sorter_core.sv
design/dcs_checker.sv
test/digitizer_coincidence_sorter_core_tb.sv
